// ===== rtl/core/iadp_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer ALU package
// Shared widths, operation codes and status codes of the integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package iadp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int KIND_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [STATUS_W-1:0]   status_t;

	localparam kind_t KIND_ADD = 3'd0;
	localparam kind_t KIND_SUB = 3'd1;
	localparam kind_t KIND_MUL = 3'd2;
	localparam kind_t KIND_DIV = 3'd3;
	localparam kind_t KIND_POW = 3'd4;

	localparam status_t STATUS_OK   = 2'd0;
	localparam status_t STATUS_DIV0 = 2'd1;
	localparam status_t STATUS_BAD  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/iadp_if.sv =====
// ----------------------------------------------------------------------------
// Integer ALU channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface iadp_req_if
	import iadp_pkg::*;
();
	logic                         valid;
	logic                         ready;
	kind_t                        kind;
	logic signed [DATA_WIDTH-1:0] operand_a;
	logic signed [DATA_WIDTH-1:0] operand_b;

	modport source (output valid, output kind, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input kind, input operand_a, input operand_b,
		output ready);
endinterface

interface iadp_rsp_if
	import iadp_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result;
	status_t                      status;

	modport source (output valid, output result, output status, input ready);
	modport sink (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_alu_div_pow_core.sv =====
// ----------------------------------------------------------------------------
// Integer ALU with divide and power
// Add, subtract, multiply, divide and power on signed words, one request
// at a time, with a registered response.
// ----------------------------------------------------------------------------
// Add, subtract, invalid codes, divide by zero and power with an exponent of
// zero or less go straight to the output state ST_OUT. Multiply passes through
// ST_MUL and the shared registered multiplier. Divide is radix-2 restoring on
// magnitudes, one quotient bit per cycle in ST_DIV, then the sign fix in
// ST_DFIX. Power uses the same multiplier for square-and-multiply, alternating
// ST_POWA and ST_POWB for each exponent bit up to its highest set bit. The
// block takes no new request while one is in progress.
`default_nettype none

module integer_alu_div_pow_core
	import iadp_pkg::*;
(
	input wire         clk,
	input wire         arst_n,
	iadp_req_if.sink   req,
	iadp_rsp_if.source rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_DFIX  = 3'd3;
	localparam logic [2:0] ST_POWA  = 3'd4;
	localparam logic [2:0] ST_POWB  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]       state_q;
	logic             rsp_valid_q;
	word_t            rsp_result_q;
	status_t          rsp_status_q;
	word_t            res_q;
	status_t          st_q;
	word_t            quo_q;
	word_t            rem_q;
	word_t            den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            acc_q;
	word_t            sq_q;
	word_t            exp_q;
	logic             first_q;

	word_t             a_w;
	word_t             b_w;
	word_t             prod;
	word_t             mul_x;
	word_t             mul_y;
	word_t             sq_cur;
	word_t             exp_next;
	word_t             acc_next;
	logic [DATA_WIDTH:0] rem_sh;
	logic [DATA_WIDTH:0] diff;
	logic              accept;
	logic              rsp_load;

	assign a_w    = word_t'(req.operand_a);
	assign b_w    = word_t'(req.operand_b);
	assign accept = req.valid && req.ready;

	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = rsp_result_q;
	assign rsp.status = rsp_status_q;

	assign rsp_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);

	assign sq_cur   = first_q ? sq_q : prod;
	assign exp_next = exp_q >> 1;
	assign acc_next = exp_q[0] ? prod : acc_q;
	assign rem_sh   = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff     = rem_sh - {1'b0, den_q};

	always_comb begin
		unique case (state_q)
			ST_POWA: begin
				mul_x = acc_q;
				mul_y = sq_cur;
			end
			ST_POWB: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			default: begin
				mul_x = a_w;
				mul_y = b_w;
			end
		endcase
	end

	iadp_mul u_mul (
		.clk  (clk),
		.op_x (mul_x),
		.op_y (mul_y),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.kind)
							KIND_ADD: begin
								res_q   <= a_w + b_w;
								st_q    <= STATUS_OK;
								state_q <= ST_OUT;
							end
							KIND_SUB: begin
								res_q   <= a_w - b_w;
								st_q    <= STATUS_OK;
								state_q <= ST_OUT;
							end
							KIND_MUL: begin
								st_q    <= STATUS_OK;
								state_q <= ST_MUL;
							end
							KIND_DIV: begin
								if (b_w == '0) begin
									res_q   <= '0;
									st_q    <= STATUS_DIV0;
									state_q <= ST_OUT;
								end else begin
									st_q    <= STATUS_OK;
									neg_q   <= a_w[DATA_WIDTH-1] ^ b_w[DATA_WIDTH-1];
									quo_q   <= a_w[DATA_WIDTH-1] ? -a_w : a_w;
									den_q   <= b_w[DATA_WIDTH-1] ? -b_w : b_w;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= ST_DIV;
								end
							end
							KIND_POW: begin
								st_q <= STATUS_OK;
								if (b_w == '0 || b_w[DATA_WIDTH-1]) begin
									res_q   <= word_t'(1);
									state_q <= ST_OUT;
								end else begin
									acc_q   <= word_t'(1);
									sq_q    <= a_w;
									exp_q   <= b_w;
									first_q <= 1'b1;
									state_q <= ST_POWA;
								end
							end
							default: begin
								res_q   <= '0;
								st_q    <= STATUS_BAD;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_MUL: begin
					res_q   <= prod;
					state_q <= ST_OUT;
				end
				ST_DIV: begin
					rem_q <= diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
						state_q <= ST_DFIX;
					end
				end
				ST_DFIX: begin
					res_q   <= neg_q ? -quo_q : quo_q;
					state_q <= ST_OUT;
				end
				ST_POWA: begin
					sq_q    <= sq_cur;
					first_q <= 1'b0;
					state_q <= ST_POWB;
				end
				ST_POWB: begin
					acc_q <= acc_next;
					exp_q <= exp_next;
					if (exp_next == '0) begin
						res_q   <= acc_next;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_POWA;
					end
				end
				ST_OUT: begin
					if (rsp_load) begin
						rsp_result_q <= res_q;
						rsp_status_q <= st_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/iadp_mul.sv =====
// ----------------------------------------------------------------------------
// Integer ALU multiplier
// Shared multiplier with a registered output: the low word of the product appears in the cycle after its operands.
// ----------------------------------------------------------------------------
`default_nettype none

module iadp_mul
	import iadp_pkg::*;
(
	input  wire   clk,
	input  word_t op_x,
	input  word_t op_y,
	output word_t prod
);

	word_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_x * op_y;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire
